/* rtl/http_response_header_parser_top_assert.svh */
// Assertion macros for the HTTP response parser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

/* rtl/hrp_pkg.sv */
// Types, constants and helper functions for the HTTP response parser.
// Used by every module of the block; depends on nothing.
package hrp_pkg;

  localparam int LINE_CAPACITY_DEF = 256;
  localparam int PREFIX_LEN        = 15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [31:0] MAG_CAP      = 32'h8000_0000;
  localparam logic [31:0] SAT_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] LEN_UNKNOWN  = 32'hFFFF_FFFF;
  localparam logic [30:0] COUNT_MAX    = 31'h7FFF_FFFF;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [2:0] {
    PH_STATUS  = 3'd0,
    PH_HEADERS = 3'd1,
    PH_BODY    = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SC_SKIP   = 2'd0,
    SC_DIGITS = 2'd1,
    SC_STOP   = 2'd2,
    SC_SEEK   = 2'd3
  } scan_t;

  typedef struct packed {
    scan_t       scan;
    logic [31:0] acc;
    logic        neg;
  } num_t;

  typedef struct packed {
    phase_t      phase;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [31:0] resp_status;
    logic [31:0] decl_length;
    logic [30:0] body_count;
  } result_t;

  // Lower-case text of the header name, one character per index.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h63;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h6C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/hrp_num_scan.sv */
// One character step of the signed decimal scanner with saturation.
// Depends on hrp_pkg.
module hrp_num_scan
  import hrp_pkg::*;
(
  input  logic [7:0] ch,
  input  num_t       cur,
  output num_t       nxt
);

  logic        is_blank;
  logic        is_digit;
  logic [31:0] base;
  logic [35:0] prod;
  logic [31:0] acc_dig;

  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign base     = (cur.scan == SC_DIGITS) ? cur.acc : 32'd0;
  assign prod     = {4'd0, base} * 36'd10 + {32'd0, 4'(ch - CH_ZERO)};
  assign acc_dig  = (prod > {4'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];

  always_comb begin
    nxt = cur;
    case (cur.scan)
      SC_SKIP: begin
        if (!is_blank) begin
          if (ch == CH_PLUS) begin
            nxt.scan = SC_DIGITS;
          end else if (ch == CH_MINUS) begin
            nxt.neg  = 1'b1;
            nxt.scan = SC_DIGITS;
          end else if (is_digit) begin
            nxt.acc  = acc_dig;
            nxt.scan = SC_DIGITS;
          end else begin
            nxt.scan = SC_STOP;
          end
        end
      end
      SC_DIGITS: begin
        if (is_digit) begin
          nxt.acc = acc_dig;
        end else begin
          nxt.scan = SC_STOP;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

/* rtl/hrp_core.sv */
// Parser state and the next-state logic for one accepted word.
// Depends on hrp_pkg and hrp_num_scan.
module hrp_core
  import hrp_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  output result_t    result
);

  localparam int COL_W = $clog2(LINE_CAPACITY);

  phase_t      phase_r,        phase_nxt;
  logic [COL_W-1:0] col_r,     col_nxt;
  num_t        stat_r,         stat_nxt;
  logic [31:0] status_value_r, status_value_nxt;
  logic [3:0]  match_pos_r,    match_pos_nxt;
  logic        match_alive_r,  match_alive_nxt;
  num_t        val_r,          val_nxt;
  logic [31:0] length_r,       length_nxt;
  logic [30:0] count_r,        count_nxt;
  logic        body_valid;

  num_t        stat_scan;
  num_t        val_scan;
  logic        len_known;
  logic [7:0]  low_ch;
  logic        col_full;
  logic        in_prefix;

  hrp_num_scan u_stat_scan (.ch(data_byte), .cur(stat_r), .nxt(stat_scan));
  hrp_num_scan u_val_scan  (.ch(data_byte), .cur(val_r),  .nxt(val_scan));

  assign len_known = !length_r[31];
  assign low_ch    = ((data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z)) ?
                     (data_byte | 8'h20) : data_byte;
  assign col_full  = (col_r >= COL_W'(LINE_CAPACITY - 1));
  assign in_prefix = (col_r < COL_W'(PREFIX_LEN));

  always_comb begin
    phase_nxt        = phase_r;
    col_nxt          = col_r;
    stat_nxt         = stat_r;
    status_value_nxt = status_value_r;
    match_pos_nxt    = match_pos_r;
    match_alive_nxt  = match_alive_r;
    val_nxt          = val_r;
    length_nxt       = length_r;
    count_nxt        = count_r;
    body_valid       = 1'b0;
    if (opcode == OP_RESTART) begin
      phase_nxt        = PH_STATUS;
      col_nxt          = '0;
      stat_nxt         = '{scan: SC_SEEK, acc: 32'd0, neg: 1'b0};
      status_value_nxt = 32'd0;
      match_pos_nxt    = 4'd0;
      match_alive_nxt  = 1'b1;
      val_nxt          = '{scan: SC_SKIP, acc: 32'd0, neg: 1'b0};
      length_nxt       = LEN_UNKNOWN;
      count_nxt        = 31'd0;
    end else begin
      unique case (phase_r) inside
        PH_BODY: begin
          if (!len_known || ({1'b0, count_r} < length_r)) begin
            body_valid = 1'b1;
            if (count_r < COUNT_MAX) begin
              count_nxt = count_r + 31'd1;
            end
          end
          if (len_known && ({1'b0, count_nxt} >= length_r)) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_STATUS, PH_HEADERS: begin
          if (data_byte == CH_LF) begin
            if ((phase_r == PH_STATUS) && (stat_r.scan == SC_SEEK)) begin
              phase_nxt = PH_ERROR;
            end else begin
              if (phase_r == PH_STATUS) begin
                if (stat_r.neg) begin
                  status_value_nxt = 32'd0 - stat_r.acc;
                end else begin
                  status_value_nxt = (stat_r.acc >= MAG_CAP) ? SAT_POS : stat_r.acc;
                end
                phase_nxt = PH_HEADERS;
              end else if (col_r == '0) begin
                phase_nxt = (length_r == 32'd0) ? PH_DONE : PH_BODY;
              end else if (match_alive_r && (match_pos_r == 4'(PREFIX_LEN))) begin
                if (val_r.neg && (val_r.acc != 32'd0)) begin
                  length_nxt = LEN_UNKNOWN;
                end else begin
                  length_nxt = (val_r.acc >= MAG_CAP) ? SAT_POS : val_r.acc;
                end
              end
              col_nxt         = '0;
              match_pos_nxt   = 4'd0;
              match_alive_nxt = 1'b1;
              val_nxt         = '{scan: SC_SKIP, acc: 32'd0, neg: 1'b0};
            end
          end else if ((data_byte != CH_CR) && !col_full) begin
            col_nxt = col_r + COL_W'(1);
            if (phase_r == PH_STATUS) begin
              if (stat_r.scan == SC_SEEK) begin
                if (data_byte == CH_SPACE) begin
                  stat_nxt.scan = SC_SKIP;
                end
              end else begin
                stat_nxt = stat_scan;
              end
            end else if (in_prefix) begin
              if (low_ch != key_char(col_r[3:0])) begin
                match_alive_nxt = 1'b0;
              end
              match_pos_nxt = col_r[3:0] + 4'd1;
            end else begin
              val_nxt = val_scan;
            end
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    result.phase       = phase_nxt;
    result.body_valid  = body_valid;
    result.body_byte   = body_valid ? data_byte : 8'd0;
    result.resp_status = status_value_nxt;
    result.decl_length = length_nxt;
    result.body_count  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_STATUS;
      col_r          <= '0;
      stat_r         <= '{scan: SC_SEEK, acc: 32'd0, neg: 1'b0};
      status_value_r <= 32'd0;
      match_pos_r    <= 4'd0;
      match_alive_r  <= 1'b1;
      val_r          <= '{scan: SC_SKIP, acc: 32'd0, neg: 1'b0};
      length_r       <= LEN_UNKNOWN;
      count_r        <= 31'd0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      col_r          <= col_nxt;
      stat_r         <= stat_nxt;
      status_value_r <= status_value_nxt;
      match_pos_r    <= match_pos_nxt;
      match_alive_r  <= match_alive_nxt;
      val_r          <= val_nxt;
      length_r       <= length_nxt;
      count_r        <= count_nxt;
    end
  end

endmodule

/* rtl/http_response_header_parser_top.sv */
// Channel    | Ports                                              | Direction
// input      | in_valid, in_stall, in_opcode, in_data_byte        | word in
// result     | out_valid, out_stall, out_parse_phase ... out_body_count | word out
//
// Each accepted word gives one result word in the next cycle; a new word can be
// accepted in every cycle, limited only by out_stall on the single result register.
// Reset (rst_n low, synchronous) returns the parser to the status line phase.
// in_stall is high only while a result is held and out_stall is high.
// Depends on hrp_pkg, hrp_core and the assertion macro header.
module http_response_header_parser_top
  import hrp_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_parse_phase,
  output logic               out_body_valid,
  output logic [7:0]         out_body_byte,
  output logic signed [31:0] out_resp_status,
  output logic signed [31:0] out_decl_length,
  output logic [30:0]        out_body_count
);

  `include "http_response_header_parser_top_assert.svh"

  logic    accept;
  result_t result;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    body_phase_ok;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  hrp_core #(.LINE_CAPACITY(LINE_CAPACITY)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_parse_phase = res_r.phase;
  assign out_body_valid  = res_r.body_valid;
  assign out_body_byte   = res_r.body_byte;
  assign out_resp_status = res_r.resp_status;
  assign out_decl_length = res_r.decl_length;
  assign out_body_count  = res_r.body_count;

  assign body_phase_ok = (out_parse_phase == PH_BODY) || (out_parse_phase == PH_DONE);

  `HRP_ASSERT_SAME(a_body_phase, out_valid && out_body_valid, body_phase_ok)
  `HRP_ASSERT_SAME(a_body_zero, out_valid && !out_body_valid, out_body_byte == 8'd0)
  `HRP_ASSERT_SAME(a_stall_full, in_stall, out_valid)
  `HRP_ASSERT_NEXT(a_accept_out, in_valid && !in_stall, out_valid)

endmodule
